// File: rtl/hop_packet_sequencer_assert.svh
// ----------------------------------------------------------------------------
// hop_packet_sequencer_assert.svh
// Assertion macros used by the hop packet sequencer top level.
// ----------------------------------------------------------------------------
`ifndef HOP_PACKET_SEQUENCER_ASSERT_SVH
`define HOP_PACKET_SEQUENCER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define HPS_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hop_packet_sequencer: assertion failed");

// next-cycle implication, checked out of reset
`define HPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hop_packet_sequencer: assertion failed");

`endif

// File: rtl/hps_pkg.sv
// ----------------------------------------------------------------------------
// hps_pkg
// Constants, codes and controller/datapath link types of the hop sequencer.
// ----------------------------------------------------------------------------
package hps_pkg;

  localparam int MAX_CHANNELS = 128;
  localparam int BURST_LIMIT  = 4;
  localparam int MAX_PAYLOAD  = 64;

  localparam int CH_CAP    = (MAX_CHANNELS < 128) ? MAX_CHANNELS : 128;
  localparam int BUDGET_W  = $clog2(BURST_LIMIT + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 32;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 32;

  localparam logic [BUDGET_W-1:0] BURST_MAX   = BUDGET_W'(BURST_LIMIT);
  localparam logic [BUDGET_W-1:0] BUDGET_STEP = BUDGET_W'(1);

  localparam logic [7:0] TPL_BYTE0  = 8'hE1;
  localparam logic [7:0] NONCE_MASK = 8'h3F;
  localparam logic [7:0] HDR_MASK   = 8'hC0;
  localparam logic [7:0] PROBE_TAG  = 8'h48;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STOP  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  localparam logic [1:0] EV_RETUNE = 2'd0;
  localparam logic [1:0] EV_PACKET = 2'd1;
  localparam logic [1:0] EV_PROBE  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_CHANNELS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_MS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PKT_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PKTS_PER_HOP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_LEN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_CACHED   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CACHED_BYTE  = 3'd6;

  typedef struct packed {
    logic load;
    logic clear_budget;
    logic start;
    logic stop;
    logic pkt_calc;
    logic look;
    logic stage_dwell;
    logic stage_probe;
    logic stage_ret;
    logic mod_step;
    logic push;
    logic last_val;
  } hps_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       active;
    logic       pkt_mode;
    logic       pkt_due;
    logic       dwell_due;
    logic       need_ret;
    logic       more_pkt;
    logic       mod_last;
    logic       out_free;
  } hps_stat_t;

endpackage

// File: rtl/hps_ctrl.sv
// ----------------------------------------------------------------------------
// hps_ctrl
// Sequencing state machine: walks one item through its result events.
// ----------------------------------------------------------------------------
module hps_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  hps_pkg::hps_stat_t stat,
  output hps_pkg::hps_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE      = 8'b0000_0001,
    S_DECIDE    = 8'b0000_0010,
    S_PKT_CALC  = 8'b0000_0100,
    S_PKT_LOOK  = 8'b0000_1000,
    S_PUSH      = 8'b0001_0000,
    S_MOD       = 8'b0010_0000,
    S_RET_STAGE = 8'b0100_0000,
    S_PROBE     = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  state_t after_r, after_nxt;
  logic   more_r, more_nxt;
  logic   dwell_r, dwell_nxt;

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    after_nxt = after_r;
    more_nxt  = more_r;
    dwell_nxt = dwell_r;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.clear_budget = 1'b1;
        if (stat.kind == hps_pkg::KIND_START) begin
          cmd.start = 1'b1;
          after_nxt = S_IDLE;
          state_nxt = S_PUSH;
        end else if (stat.kind == hps_pkg::KIND_STOP) begin
          cmd.stop  = 1'b1;
          state_nxt = S_IDLE;
        end else if (stat.kind == hps_pkg::KIND_TICK && stat.active) begin
          if (stat.pkt_mode) begin
            state_nxt = stat.pkt_due ? S_PKT_CALC : S_IDLE;
          end else if (stat.dwell_due) begin
            cmd.stage_dwell = 1'b1;
            dwell_nxt       = 1'b1;
            after_nxt       = S_PROBE;
            state_nxt       = S_PUSH;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_PKT_CALC: begin
        cmd.pkt_calc = 1'b1;
        dwell_nxt    = 1'b0;
        state_nxt    = S_PKT_LOOK;
      end
      S_PKT_LOOK: begin
        cmd.look     = 1'b1;
        cmd.last_val = !(stat.need_ret || stat.more_pkt);
        more_nxt     = stat.more_pkt;
        if (stat.need_ret) begin
          after_nxt = S_MOD;
        end else if (stat.more_pkt) begin
          after_nxt = S_PKT_CALC;
        end else begin
          after_nxt = S_IDLE;
        end
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = after_r;
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = dwell_r ? S_IDLE : S_RET_STAGE;
        end
      end
      S_RET_STAGE: begin
        cmd.stage_ret = 1'b1;
        cmd.last_val  = !more_r;
        after_nxt     = more_r ? S_PKT_CALC : S_IDLE;
        state_nxt     = S_PUSH;
      end
      S_PROBE: begin
        cmd.stage_probe = 1'b1;
        after_nxt       = S_MOD;
        state_nxt       = S_PUSH;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      after_r <= S_IDLE;
      more_r  <= 1'b0;
      dwell_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      after_r <= after_nxt;
      more_r  <= more_nxt;
      dwell_r <= dwell_nxt;
    end
  end

endmodule

// File: rtl/hps_dp.sv
// ----------------------------------------------------------------------------
// hps_dp
// Datapath: registers, hop state, due checks, channel modulo and output stage.
// ----------------------------------------------------------------------------
module hps_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [hps_pkg::IN_DATA_W-1:0]      in_tdata,
  input  logic [1:0]                         in_tuser,
  input  logic                               cfg_wr,
  input  logic [hps_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [hps_pkg::CFG_DAT_W-1:0]      cfg_data,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [hps_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic [1:0]                         out_tuser,
  output logic                               out_tlast,
  input  hps_pkg::hps_cmd_t                  cmd,
  output hps_pkg::hps_stat_t                 stat
);

  // configuration
  logic [7:0]  num_ch_r;
  logic [15:0] dwell_ms_r;
  logic [31:0] pkt_int_r;
  logic [7:0]  pph_r;
  logic [6:0]  plen_r;
  logic        use_cached_r;
  logic [7:0]  cached_b0_r;

  // hop state
  logic                         active_r;
  logic [6:0]                   hop_r;
  logic [7:0]                   seq_r;
  logic [7:0]                   sent_r;
  logic [31:0]                  next_hop_ms_r;
  logic [31:0]                  next_pkt_us_r;
  logic [hps_pkg::BUDGET_W-1:0] budget_r;
  logic [2:0]                   mod_cnt_r;
  logic [7:0]                   rem_r;

  // item and result stage
  logic [1:0]  kind_r;
  logic [31:0] now_ms_r;
  logic [31:0] now_us_r;
  logic [1:0]  st_ev_r;
  logic [6:0]  st_ch_r;
  logic [7:0]  st_b0_r, st_b2_r, st_b1_r;
  logic        st_last_r;

  logic        out_valid_r;
  logic [1:0]  out_ev_r;
  logic [6:0]  out_ch_r;
  logic [7:0]  out_b0_r, out_b2_r, out_b1_r;
  logic        out_last_r;

  logic [7:0]  eff_ch;
  logic [6:0]  len;
  logic [31:0] pkt_diff, hop_diff;
  logic [7:0]  mod_x, rem_in, rem_sh, rem_nxt;
  logic [7:0]  pb0, pb2, pb1;

  always_comb begin
    if (num_ch_r == 8'd0) begin
      eff_ch = 8'd1;
    end else if (num_ch_r > 8'(hps_pkg::CH_CAP)) begin
      eff_ch = 8'(hps_pkg::CH_CAP);
    end else begin
      eff_ch = num_ch_r;
    end
  end

  assign len = (plen_r > 7'(hps_pkg::MAX_PAYLOAD)) ? 7'(hps_pkg::MAX_PAYLOAD) : plen_r;

  assign pkt_diff = now_us_r - next_pkt_us_r;
  assign hop_diff = now_ms_r - next_hop_ms_r;

  // restoring remainder of (hop + 1) by the channel count, one bit a cycle
  assign mod_x   = {1'b0, hop_r} + 8'd1;
  assign rem_in  = (mod_cnt_r == 3'd0) ? 8'd0 : rem_r;
  assign rem_sh  = {rem_in[6:0], mod_x[3'd7 - mod_cnt_r]};
  assign rem_nxt = (rem_sh >= eff_ch) ? (rem_sh - eff_ch) : rem_sh;

  always_comb begin
    pb2 = 8'd0;
    pb1 = 8'd0;
    if (use_cached_r) begin
      pb0 = (cached_b0_r & hps_pkg::HDR_MASK) | (seq_r & hps_pkg::NONCE_MASK);
    end else begin
      pb1 = seq_r;
      if (len == 7'd1) begin
        pb0 = seq_r;
      end else begin
        pb2 = {1'b0, hop_r};
        pb0 = (len == 7'd2) ? {1'b0, hop_r} : hps_pkg::TPL_BYTE0;
      end
    end
  end

  assign stat.kind      = kind_r;
  assign stat.active    = active_r;
  assign stat.pkt_mode  = (pkt_int_r != 32'd0) && (pph_r != 8'd0) && (plen_r != 7'd0);
  assign stat.pkt_due   = !pkt_diff[31];
  assign stat.dwell_due = !hop_diff[31];
  assign stat.need_ret  = (sent_r >= pph_r);
  assign stat.more_pkt  = (budget_r < hps_pkg::BURST_MAX) && !pkt_diff[31];
  assign stat.mod_last  = (mod_cnt_r == 3'd7);
  assign stat.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_ch_r      <= 8'd1;
      dwell_ms_r    <= 16'd1;
      pkt_int_r     <= 32'd0;
      pph_r         <= 8'd0;
      plen_r        <= 7'd0;
      use_cached_r  <= 1'b0;
      cached_b0_r   <= 8'd0;
      active_r      <= 1'b0;
      hop_r         <= 7'd0;
      seq_r         <= 8'd0;
      sent_r        <= 8'd0;
      next_hop_ms_r <= 32'd0;
      next_pkt_us_r <= 32'd0;
      budget_r      <= '0;
      mod_cnt_r     <= 3'd0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_addr)
          hps_pkg::CFG_NUM_CHANNELS: num_ch_r     <= cfg_data[7:0];
          hps_pkg::CFG_DWELL_MS:     dwell_ms_r   <= cfg_data[15:0];
          hps_pkg::CFG_PKT_INTERVAL: pkt_int_r    <= cfg_data;
          hps_pkg::CFG_PKTS_PER_HOP: pph_r        <= cfg_data[7:0];
          hps_pkg::CFG_PAYLOAD_LEN:  plen_r       <= cfg_data[6:0];
          hps_pkg::CFG_USE_CACHED:   use_cached_r <= cfg_data[0];
          hps_pkg::CFG_CACHED_BYTE:  cached_b0_r  <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (cmd.clear_budget) begin
        budget_r <= '0;
      end
      if (cmd.start) begin
        hop_r         <= 7'd0;
        seq_r         <= 8'd0;
        sent_r        <= 8'd0;
        next_hop_ms_r <= now_ms_r;
        next_pkt_us_r <= now_us_r;
        active_r      <= 1'b1;
      end
      if (cmd.stop) begin
        active_r  <= 1'b0;
        sent_r    <= 8'd0;
        pkt_int_r <= 32'd0;
        pph_r     <= 8'd0;
        plen_r    <= 7'd0;
      end
      if (cmd.pkt_calc) begin
        seq_r         <= seq_r + 8'd1;
        sent_r        <= sent_r + 8'd1;
        next_pkt_us_r <= next_pkt_us_r + pkt_int_r;
        budget_r      <= budget_r + hps_pkg::BUDGET_STEP;
      end
      if (cmd.look && stat.need_ret) begin
        sent_r <= 8'd0;
      end
      if (cmd.stage_dwell) begin
        next_hop_ms_r <= now_ms_r + {16'd0, dwell_ms_r};
      end
      if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r + 3'd1;
        if (mod_cnt_r == 3'd7) begin
          hop_r <= rem_nxt[6:0];
        end
      end
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r   <= in_tuser;
      now_ms_r <= in_tdata[31:0];
      now_us_r <= in_tdata[63:32];
    end
    if (cmd.mod_step) begin
      rem_r <= rem_nxt;
    end
    if (cmd.start) begin
      st_ev_r   <= hps_pkg::EV_RETUNE;
      st_ch_r   <= 7'd0;
      st_b0_r   <= 8'd0;
      st_b2_r   <= 8'd0;
      st_b1_r   <= 8'd0;
      st_last_r <= 1'b1;
    end
    if (cmd.pkt_calc) begin
      st_ev_r   <= hps_pkg::EV_PACKET;
      st_ch_r   <= hop_r;
      st_b0_r   <= pb0;
      st_b2_r   <= pb2;
      st_b1_r   <= pb1;
      st_last_r <= 1'b0;
    end
    if (cmd.look) begin
      st_last_r <= cmd.last_val;
    end
    if (cmd.stage_dwell || cmd.stage_ret) begin
      st_ev_r   <= hps_pkg::EV_RETUNE;
      st_ch_r   <= hop_r;
      st_b0_r   <= 8'd0;
      st_b2_r   <= 8'd0;
      st_b1_r   <= 8'd0;
      st_last_r <= cmd.stage_ret ? cmd.last_val : 1'b0;
    end
    if (cmd.stage_probe) begin
      st_ev_r   <= hps_pkg::EV_PROBE;
      st_ch_r   <= hop_r;
      st_b0_r   <= hps_pkg::PROBE_TAG;
      st_b2_r   <= 8'd0;
      st_b1_r   <= {1'b0, hop_r};
      st_last_r <= 1'b1;
    end
    if (cmd.push) begin
      out_ev_r   <= st_ev_r;
      out_ch_r   <= st_ch_r;
      out_b0_r   <= st_b0_r;
      out_b2_r   <= st_b2_r;
      out_b1_r   <= st_b1_r;
      out_last_r <= st_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ev_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {1'b0, out_b1_r, out_b2_r, out_b0_r, out_ch_r};

endmodule

// File: rtl/hop_packet_sequencer.sv
// ----------------------------------------------------------------------------
// hop_packet_sequencer
// Frequency-hopping transmit sequencer. Takes start, stop and tick items and
// emits retune, packet and probe events, the final event of an item marked
// by out_tlast. One item is in work at a time. In packet mode the retune
// after a full hop waits for the next channel from a bit-serial remainder
// unit; a dwell hop emits a retune plus a probe. A stalled output stretches
// the work on an item. Configuration writes are taken in any cycle but belong
// to idle periods.
// ----------------------------------------------------------------------------
`include "hop_packet_sequencer_assert.svh"

module hop_packet_sequencer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [hps_pkg::IN_DATA_W-1:0]    in_tdata,   // now_ms[31:0], now_us[63:32]
  input  logic [1:0]                       in_tuser,   // kind[1:0]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [hps_pkg::OUT_DATA_W-1:0]   out_tdata,  // channel_index[6:0],
                                                       // first_byte[14:7],
                                                       // second_last_byte[22:15],
                                                       // last_byte[30:23], zero[31]
  output logic [1:0]                       out_tuser,  // event_res[1:0]
  output logic                             out_tlast,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [hps_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [hps_pkg::CFG_DAT_W-1:0]    cfg_data
);

  hps_pkg::hps_cmd_t  cmd;
  hps_pkg::hps_stat_t stat;
  logic [9:0]         cmd_act;

  assign cfg_ready = 1'b1;

  assign cmd_act = {cmd.load, cmd.start, cmd.stop, cmd.pkt_calc, cmd.look,
                    cmd.stage_dwell, cmd.stage_probe, cmd.stage_ret, cmd.mod_step, cmd.push};

  hps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  hps_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_wr     (cfg_valid && cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .stat       (stat)
  );

  `HPS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)
  `HPS_ASSERT_IMPL(a_push_when_free, cmd.push, !out_tvalid || out_tready)
  `HPS_ASSERT_IMPL(a_single_cmd, 1'b1, $onehot0(cmd_act))

endmodule

// File: bench/hps_event_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hps_event_checker
// Watches the item, result and register channels of the hop packet sequencer,
// predicts the retune, packet and probe events of every accepted item and
// compares each accepted result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module hps_event_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [hps_pkg::IN_DATA_W-1:0]  in_tdata,   // now_ms[31:0], now_us[63:32]
  input  logic [1:0]                     in_tuser,   // kind[1:0]
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [hps_pkg::OUT_DATA_W-1:0] out_tdata,  // channel_index[6:0],
                                                     // first_byte[14:7],
                                                     // second_last_byte[22:15],
                                                     // last_byte[30:23], zero[31]
  input  logic [1:0]                     out_tuser,  // event_res[1:0]
  input  logic                           out_tlast,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [hps_pkg::CFG_DAT_W-1:0]  cfg_data,
  output int                             n_fail,
  output int                             n_due
);

  typedef struct packed {
    logic [1:0] ev;
    logic [6:0] chan;
    logic [7:0] b_first;
    logic [7:0] b_second_last;
    logic [7:0] b_last;
    logic       fin;
  } hop_event_t;

  hop_event_t hop_events_due[$];
  hop_event_t head;

  logic [7:0]  r_nch;
  logic [15:0] r_dwell;
  logic [31:0] r_interval;
  logic [7:0]  r_pph;
  logic [6:0]  r_plen;
  logic        r_cached;
  logic [7:0]  r_cbyte;

  logic        armed;
  logic [6:0]  hop_idx;
  logic [7:0]  seq;
  logic [7:0]  sent;
  logic [31:0] due_hop_ms;
  logic [31:0] due_pkt_us;

  task automatic flag_miss(input string what, input logic [31:0] got, input logic [31:0] want);
    n_fail++;
    $display("%t hps check: %s got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic hop_event_t pack_event(input logic [1:0] e, input logic [6:0] c,
                                            input logic [7:0] b0, input logic [7:0] b2,
                                            input logic [7:0] b1);
    pack_event = {e, c, b0, b2, b1, 1'b0};
  endfunction

  function automatic logic is_due(input logic [31:0] now_t, input logic [31:0] when_t);
    logic [31:0] d;
    d = now_t - when_t;
    return ~d[31];
  endfunction

  task automatic step_channel();
    int eff;
    eff = (r_nch == 8'd0) ? 1 : ((int'(r_nch) > hps_pkg::CH_CAP) ? hps_pkg::CH_CAP
                                                                  : int'(r_nch));
    hop_idx = 7'((int'(hop_idx) + 1) % eff);
  endtask

  task automatic predict_hop_events(input logic [1:0] kind, input logic [31:0] ms,
                                    input logic [31:0] us);
    hop_event_t ev_buf [0:7];
    int n;
    int slots;
    int len;
    logic [7:0] fb, sb, lb;
    n = 0;
    if (kind == hps_pkg::KIND_START) begin
      hop_idx = '0;
      seq = '0;
      sent = '0;
      due_hop_ms = ms;
      due_pkt_us = us;
      armed = 1'b1;
      ev_buf[n] = pack_event(hps_pkg::EV_RETUNE, 7'd0, 8'd0, 8'd0, 8'd0);
      n++;
    end else if (kind == hps_pkg::KIND_STOP) begin
      armed = 1'b0;
      r_interval = '0;
      r_pph = '0;
      r_plen = '0;
      sent = '0;
    end else if (kind == hps_pkg::KIND_TICK && armed) begin
      if (r_interval != 0 && r_pph != 0 && r_plen != 0) begin
        len = (int'(r_plen) > hps_pkg::MAX_PAYLOAD) ? hps_pkg::MAX_PAYLOAD : int'(r_plen);
        slots = 0;
        while (slots < hps_pkg::BURST_LIMIT && is_due(us, due_pkt_us)) begin
          sb = 8'd0;
          lb = 8'd0;
          if (r_cached) begin
            fb = (r_cbyte & hps_pkg::HDR_MASK) | (seq & hps_pkg::NONCE_MASK);
          end else begin
            lb = seq;
            if (len == 1) begin
              fb = seq;
            end else begin
              sb = {1'b0, hop_idx};
              fb = (len == 2) ? {1'b0, hop_idx} : hps_pkg::TPL_BYTE0;
            end
          end
          seq = seq + 8'd1;
          ev_buf[n] = pack_event(hps_pkg::EV_PACKET, hop_idx, fb, sb, lb);
          n++;
          sent = sent + 8'd1;
          if (sent >= r_pph) begin
            sent = '0;
            step_channel();
            ev_buf[n] = pack_event(hps_pkg::EV_RETUNE, hop_idx, 8'd0, 8'd0, 8'd0);
            n++;
          end
          due_pkt_us = due_pkt_us + r_interval;
          slots++;
        end
      end else if (is_due(ms, due_hop_ms)) begin
        ev_buf[n] = pack_event(hps_pkg::EV_RETUNE, hop_idx, 8'd0, 8'd0, 8'd0);
        n++;
        ev_buf[n] = pack_event(hps_pkg::EV_PROBE, hop_idx, hps_pkg::PROBE_TAG, 8'd0,
                               {1'b0, hop_idx});
        n++;
        step_channel();
        due_hop_ms = ms + {16'd0, r_dwell};
      end
    end
    for (int i = 0; i < n; i++) begin
      ev_buf[i].fin = (i == n - 1);
      hop_events_due.push_back(ev_buf[i]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      r_nch = 8'd1;
      r_dwell = 16'd1;
      r_interval = '0;
      r_pph = '0;
      r_plen = '0;
      r_cached = 1'b0;
      r_cbyte = '0;
      armed = 1'b0;
      hop_idx = '0;
      seq = '0;
      sent = '0;
      due_hop_ms = '0;
      due_pkt_us = '0;
      n_fail = 0;
      n_due = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_addr)
          hps_pkg::CFG_NUM_CHANNELS: r_nch = cfg_data[7:0];
          hps_pkg::CFG_DWELL_MS:     r_dwell = cfg_data[15:0];
          hps_pkg::CFG_PKT_INTERVAL: r_interval = cfg_data;
          hps_pkg::CFG_PKTS_PER_HOP: r_pph = cfg_data[7:0];
          hps_pkg::CFG_PAYLOAD_LEN:  r_plen = cfg_data[6:0];
          hps_pkg::CFG_USE_CACHED:   r_cached = cfg_data[0];
          hps_pkg::CFG_CACHED_BYTE:  r_cbyte = cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        if (hop_events_due.size() == 0) begin
          flag_miss("event with no pending item", out_tdata, 32'd0);
        end else begin
          head = hop_events_due.pop_front();
          if (out_tuser !== head.ev)
            flag_miss("event_res", 32'(out_tuser), 32'(head.ev));
          if (out_tdata[6:0] !== head.chan)
            flag_miss("channel_index", 32'(out_tdata[6:0]), 32'(head.chan));
          if (out_tdata[14:7] !== head.b_first)
            flag_miss("first_byte", 32'(out_tdata[14:7]), 32'(head.b_first));
          if (out_tdata[22:15] !== head.b_second_last)
            flag_miss("second_last_byte", 32'(out_tdata[22:15]), 32'(head.b_second_last));
          if (out_tdata[30:23] !== head.b_last)
            flag_miss("last_byte", 32'(out_tdata[30:23]), 32'(head.b_last));
          if (out_tdata[31] !== 1'b0)
            flag_miss("tdata padding", 32'(out_tdata[31]), 32'd0);
          if (out_tlast !== head.fin)
            flag_miss("tlast", 32'(out_tlast), 32'(head.fin));
        end
      end
      if (in_tvalid && in_tready)
        predict_hop_events(in_tuser, in_tdata[31:0], in_tdata[63:32]);
      n_due = hop_events_due.size();
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives start, stop and tick items into the hop packet sequencer: a directed
// run over time wrap, burst limit, channel count and payload length corner
// cases, then random hop sequences under several register settings, with
// random idling on both sides and one long output stall. The event checker
// scores every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int         CYCLE_LIMIT   = 400000;
  localparam int         SETTLE_CYCLES = 16;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         HOLD_AT       = 120;
  localparam int         ITEM_TARGET   = 430;
  localparam logic [1:0] KIND_UNKNOWN  = 2'd3;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [hps_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [1:0]                     in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [hps_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [1:0]                     out_tuser;
  logic                           out_tlast;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [hps_pkg::CFG_IDX_W-1:0]  cfg_addr;
  logic [hps_pkg::CFG_DAT_W-1:0]  cfg_data;

  int          n_fail;
  int          n_due;
  int          cycles = 0;
  int          sent_items = 0;
  int          hold_left = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          held = 1'b0;
  logic [31:0] t_ms;
  logic [31:0] t_us;
  logic [15:0] cur_dwell;
  logic [31:0] cur_ivl;

  hop_packet_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  hps_event_checker events_check (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_addr(cfg_addr), .cfg_data(cfg_data),
    .n_fail(n_fail), .n_due(n_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("hop_packet_sequencer: mismatch");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(gaps_on && $urandom_range(0, 99) < 6);
      end
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [31:0] ms, input logic [31:0] us);
    while (gaps_on && $urandom_range(0, 99) < 6) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {us, ms};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    if (k != KIND_UNKNOWN) sent_items++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (n_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [hps_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic apply_setting(input logic [7:0] nch, input logic [15:0] dwell,
                               input logic [31:0] ivl, input logic [7:0] pph,
                               input logic [6:0] plen, input logic use_c,
                               input logic [7:0] cbyte);
    cur_dwell = dwell;
    cur_ivl = ivl;
    write_reg(hps_pkg::CFG_NUM_CHANNELS, {24'd0, nch});
    write_reg(hps_pkg::CFG_DWELL_MS, {16'd0, dwell});
    write_reg(hps_pkg::CFG_PKT_INTERVAL, ivl);
    write_reg(hps_pkg::CFG_PKTS_PER_HOP, {24'd0, pph});
    write_reg(hps_pkg::CFG_PAYLOAD_LEN, {25'd0, plen});
    write_reg(hps_pkg::CFG_USE_CACHED, {31'd0, use_c});
    write_reg(hps_pkg::CFG_CACHED_BYTE, {24'd0, cbyte});
  endtask

  initial begin
    logic [7:0]  nch_pick;
    logic [15:0] dwell_pick;
    logic [31:0] ivl_pick;
    logic [7:0]  pph_pick;
    logic [6:0]  plen_pick;
    int          r;
    int          run_len;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = hps_pkg::KIND_START;
    cfg_valid = 1'b0;
    cfg_addr = hps_pkg::CFG_NUM_CHANNELS;
    cfg_data = '0;
    cur_dwell = 16'd1;
    cur_ivl = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings: dwell mode on one channel, idle items, wrap of the ms due time
    send_item(hps_pkg::KIND_TICK, 32'd0, 32'd0);
    send_item(hps_pkg::KIND_STOP, 32'd0, 32'd0);
    send_item(KIND_UNKNOWN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(hps_pkg::KIND_START, 32'hFFFF_FFFF, 32'd0);
    send_item(hps_pkg::KIND_TICK, 32'd0, 32'd0);
    send_item(hps_pkg::KIND_TICK, 32'd0, 32'd0);
    settle();

    apply_setting(8'd0, 16'hFFFF, 32'd0, 8'd0, 7'd0, 1'b0, 8'd0);
    send_item(hps_pkg::KIND_START, 32'd5, 32'd0);
    send_item(hps_pkg::KIND_TICK, 32'h8000_0005, 32'd0);
    send_item(hps_pkg::KIND_TICK, 32'd5, 32'd0);
    send_item(hps_pkg::KIND_TICK, 32'd10, 32'd0);
    settle();

    apply_setting(8'd200, 16'd1, 32'd1, 8'd1, 7'd1, 1'b0, 8'hFF);
    send_item(hps_pkg::KIND_START, 32'd0, 32'hFFFF_FFFE);
    send_item(hps_pkg::KIND_TICK, 32'd0, 32'd8);
    send_item(hps_pkg::KIND_TICK, 32'd0, 32'd7);
    settle();

    apply_setting(8'd3, 16'd1, 32'hFFFF_FFFF, 8'd255, 7'd2, 1'b0, 8'd0);
    send_item(hps_pkg::KIND_START, 32'd0, 32'd0);
    send_item(hps_pkg::KIND_TICK, 32'd0, 32'd0);
    send_item(hps_pkg::KIND_TICK, 32'd0, 32'h8000_0000);
    settle();

    apply_setting(8'd5, 16'd7, 32'd100, 8'd3, 7'd127, 1'b1, 8'hFF);
    send_item(hps_pkg::KIND_START, 32'd1000, 32'd1000);
    send_item(hps_pkg::KIND_TICK, 32'd1000, 32'd1350);
    send_item(hps_pkg::KIND_STOP, 32'd1000, 32'd1350);
    send_item(hps_pkg::KIND_TICK, 32'd2000, 32'd2000);
    send_item(hps_pkg::KIND_START, 32'd2000, 32'd0);
    send_item(hps_pkg::KIND_TICK, 32'd2000, 32'd0);
    settle();

    apply_setting(8'd128, 16'd1, 32'd50, 8'd2, 7'd64, 1'b0, 8'h3F);
    send_item(hps_pkg::KIND_START, 32'd0, 32'd0);
    send_item(hps_pkg::KIND_TICK, 32'd0, 32'd200);

    while (sent_items < ITEM_TARGET) begin
      settle();
      r = $urandom_range(0, 9);
      nch_pick = (r == 0) ? 8'd0 : (r == 1) ? 8'd128 : (r == 2) ? 8'($urandom_range(0, 255))
                                                               : 8'($urandom_range(1, 6));
      r = $urandom_range(0, 9);
      dwell_pick = (r == 0) ? 16'hFFFF : (r == 1) ? 16'($urandom_range(1, 65535))
                                                  : 16'($urandom_range(1, 20));
      r = $urandom_range(0, 19);
      ivl_pick = (r == 0) ? 32'hFFFF_FFFF : (r == 1) ? $urandom : 32'($urandom_range(1, 600));
      r = $urandom_range(0, 19);
      pph_pick = (r == 0) ? 8'd255 : (r == 1) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(1, 5));
      r = $urandom_range(0, 9);
      plen_pick = (r < 3) ? 7'($urandom_range(1, 2)) : (r < 5) ? 7'd64 :
                  (r < 7) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(3, 63));
      if ($urandom_range(0, 9) < 3) begin
        case ($urandom_range(0, 2))
          0: ivl_pick = '0;
          1: pph_pick = '0;
          default: plen_pick = '0;
        endcase
      end
      apply_setting(nch_pick, dwell_pick, ivl_pick, pph_pick, plen_pick,
                    1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));

      t_ms = $urandom;
      t_us = $urandom;
      send_item(hps_pkg::KIND_START, t_ms, t_us);
      run_len = ($urandom_range(0, 9) == 0) ? 90 : $urandom_range(4, 30);
      for (int i = 0; i < run_len; i++) begin
        if (!held && sent_items >= HOLD_AT) begin
          held = 1'b1;
          hold_req = 1'b1;
        end
        gaps_on = !(sent_items >= 220 && sent_items < 300);
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_item(2'($urandom_range(0, 3)), $urandom, $urandom);
        end else if (r < 10) begin
          send_item(hps_pkg::KIND_STOP, t_ms, t_us);
        end else begin
          if (cur_dwell <= 40) t_ms = t_ms + $urandom_range(0, 2 * cur_dwell + 1);
          else if ($urandom_range(0, 3) == 0) t_ms = t_ms + cur_dwell;
          else t_ms = t_ms + $urandom_range(0, 50);
          if (cur_ivl <= 1000) t_us = t_us + $urandom_range(0, 5 * cur_ivl + 1);
          else if ($urandom_range(0, 1) == 0) t_us = t_us + cur_ivl;
          else t_us = t_us + $urandom;
          send_item(hps_pkg::KIND_TICK, t_ms, t_us);
        end
      end
      if ($urandom_range(0, 3) == 0) send_item(hps_pkg::KIND_STOP, t_ms, t_us);
    end
    gaps_on = 1'b1;

    settle();
    repeat (4 * SETTLE_CYCLES) @(negedge clk);
    if (n_fail == 0) begin
      $display("hop_packet_sequencer: match");
    end else begin
      $display("hop_packet_sequencer: mismatch");
    end
    $finish;
  end

endmodule
